// ----- design/mm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_pkg
// Shared types and constants of the matrix multiply core.
// ----------------------------------------------------------------------------
package mm_pkg;

  localparam int MAX_DIM_DEFAULT = 8;

  localparam int DATA_W   = 32;
  localparam int FRAC_W   = 16;
  localparam int IDX_FLD_W = 3;
  localparam int DIM_REG_W = 4;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 2;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 40;

  localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

// ----- design/mm_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_store
// Element store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mm_store
  import mm_pkg::*;
#(
  parameter int DEPTH  = MAX_DIM_DEFAULT * MAX_DIM_DEFAULT,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- design/mm_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_mac
// Shared multiply-accumulate unit: registered 32x32 product, exact wide
// accumulator, floor shift by the fraction width and 32-bit saturation.
// ----------------------------------------------------------------------------
module mm_mac
  import mm_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  mac_ctl_t          ctl,
  input  logic [DATA_W-1:0] a_data,
  input  logic [DATA_W-1:0] b_data,
  output logic              done,
  output logic [DATA_W-1:0] result,
  output logic              saturated
);

  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + 1 + $clog2(MAX_DIM);
  localparam int SH_W   = ACC_W - FRAC_W;

  mac_ctl_t                   ctl_q;
  mac_ctl_t                   ctl_p;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    acc_next;
  logic        [SH_W-1:0]     shifted;
  logic        [SH_W-DATA_W:0] upper;

  // control lines up with the registered store read
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q <= '0;
      ctl_p <= '0;
      done  <= 1'b0;
    end else begin
      ctl_q <= ctl;
      ctl_p <= ctl_q;
      done  <= ctl_p.valid && ctl_p.last;
    end
  end

  always_ff @(posedge clk) begin
    prod <= $signed(a_data) * $signed(b_data);
  end

  always_comb begin
    if (ctl_p.first) begin
      acc_next = ACC_W'(prod);
    end else begin
      acc_next = acc + ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_p.valid) begin
      acc <= acc_next;
    end
  end

  assign shifted = acc[ACC_W-1:FRAC_W];
  assign upper   = shifted[SH_W-1:DATA_W-1];

  always_comb begin
    if ((&upper) || !(|upper)) begin
      result    = shifted[DATA_W-1:0];
      saturated = 1'b0;
    end else begin
      result    = upper[SH_W-DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                     : {1'b0, {(DATA_W-1){1'b1}}};
      saturated = 1'b1;
    end
  end

endmodule

// ----- design/matrix_multiply_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_core
// Element writes are accepted back to back while the core is idle.
// A compute transfer emits rows_a*cols_b entries, each dimension clamped
// to 1..MAX_DIM; entries are computed one after another by the single
// multiply-accumulate unit through its store read, product and accumulate
// registers. Input is not ready while a product is under way. Synchronous
// reset sets all dimensions to 1; stores are not cleared.
// ----------------------------------------------------------------------------
module matrix_multiply_core
  import mm_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_REG_W-1:0] cfg_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // row, col, value, zero pad
  input  logic [CMD_W-1:0]     s_axis_tuser,  // cmd
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // out_row, out_col, out_value, pad
  output logic                 m_axis_tuser,  // saturated
  output logic                 m_axis_tlast   // last
);

  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(MAX_DIM + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]           state;
  logic [DIM_REG_W-1:0] rows_a;
  logic [DIM_REG_W-1:0] inner_dim;
  logic [DIM_REG_W-1:0] cols_b;
  logic [CNT_W-1:0]     m_dim;
  logic [CNT_W-1:0]     n_dim;
  logic [CNT_W-1:0]     p_dim;
  logic [IDX_W-1:0]     i_cnt;
  logic [IDX_W-1:0]     j_cnt;
  logic [IDX_W-1:0]     k_cnt;

  logic [IDX_FLD_W-1:0] in_row;
  logic [IDX_FLD_W-1:0] in_col;
  logic [DATA_W-1:0]    in_value;
  logic                 in_xfer;
  logic                 wr_ok;
  logic [ADDR_W-1:0]    waddr;
  logic [ADDR_W-1:0]    a_raddr;
  logic [ADDR_W-1:0]    b_raddr;
  logic [DATA_W-1:0]    a_rdata;
  logic [DATA_W-1:0]    b_rdata;

  mac_ctl_t             ctl;
  logic                 k_last;
  logic                 j_last;
  logic                 i_last;
  logic                 mac_done;
  logic [DATA_W-1:0]    mac_result;
  logic                 mac_sat;
  logic                 out_load;

  function automatic logic [CNT_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] d);
    logic [CNT_W-1:0] r;
    if (d == '0) begin
      r = CNT_W'(1);
    end else if (d > DIM_REG_W'(MAX_DIM)) begin
      r = CNT_W'(MAX_DIM);
    end else begin
      r = CNT_W'(d);
    end
    return r;
  endfunction

  assign in_row   = s_axis_tdata[IDX_FLD_W-1:0];
  assign in_col   = s_axis_tdata[2*IDX_FLD_W-1:IDX_FLD_W];
  assign in_value = s_axis_tdata[2*IDX_FLD_W+DATA_W-1:2*IDX_FLD_W];

  assign s_axis_tready = (state == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign wr_ok         = ({1'b0, in_row} < (IDX_FLD_W+1)'(MAX_DIM)) &&
                         ({1'b0, in_col} < (IDX_FLD_W+1)'(MAX_DIM));
  assign waddr         = ADDR_W'(in_row * MAX_DIM + in_col);

  assign a_raddr = ADDR_W'(i_cnt * MAX_DIM + k_cnt);
  assign b_raddr = ADDR_W'(k_cnt * MAX_DIM + j_cnt);

  assign k_last = (CNT_W'(k_cnt) == n_dim - CNT_W'(1));
  assign j_last = (CNT_W'(j_cnt) == p_dim - CNT_W'(1));
  assign i_last = (CNT_W'(i_cnt) == m_dim - CNT_W'(1));

  assign ctl.valid = (state == ST_ISSUE);
  assign ctl.first = (k_cnt == '0);
  assign ctl.last  = k_last;

  assign out_load = (state == ST_OUT) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= DIM_REG_W'(1);
      inner_dim <= DIM_REG_W'(1);
      cols_b    <= DIM_REG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS_A:    rows_a    <= cfg_data;
        CFG_INNER_DIM: inner_dim <= cfg_data;
        CFG_COLS_B:    cols_b    <= cfg_data;
        default:       ;
      endcase
    end
  end

  mm_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_a_store (
    .clk   (clk),
    .we    (in_xfer && (s_axis_tuser == CMD_WRITE_A) && wr_ok),
    .waddr (waddr),
    .wdata (in_value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mm_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_b_store (
    .clk   (clk),
    .we    (in_xfer && (s_axis_tuser == CMD_WRITE_B) && wr_ok),
    .waddr (waddr),
    .wdata (in_value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  mm_mac #(
    .MAX_DIM (MAX_DIM)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .a_data    (a_rdata),
    .b_data    (b_rdata),
    .done      (mac_done),
    .result    (mac_result),
    .saturated (mac_sat)
  );

  // sequencer over entries (i, j) and inner index k
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i_cnt <= '0;
      j_cnt <= '0;
      k_cnt <= '0;
      m_dim <= CNT_W'(1);
      n_dim <= CNT_W'(1);
      p_dim <= CNT_W'(1);
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_xfer && (s_axis_tuser == CMD_COMPUTE)) begin
            m_dim <= clamp_dim(rows_a);
            n_dim <= clamp_dim(inner_dim);
            p_dim <= clamp_dim(cols_b);
            i_cnt <= '0;
            j_cnt <= '0;
            k_cnt <= '0;
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (k_last) begin
            k_cnt <= '0;
            state <= ST_WAIT;
          end else begin
            k_cnt <= k_cnt + IDX_W'(1);
          end
        end
        ST_WAIT: begin
          if (mac_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            if (j_last && i_last) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_ISSUE;
              if (j_last) begin
                j_cnt <= '0;
                i_cnt <= i_cnt + IDX_W'(1);
              end else begin
                j_cnt <= j_cnt + IDX_W'(1);
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {{(M_TDATA_W-2*IDX_FLD_W-DATA_W){1'b0}}, mac_result,
                       IDX_FLD_W'(j_cnt), IDX_FLD_W'(i_cnt)};
      m_axis_tuser <= mac_sat;
      m_axis_tlast <= j_last && i_last;
    end
  end

endmodule

// ----- design/mm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_checker
// Port-level checks of the matrix multiply core, bound to the top level.
// ----------------------------------------------------------------------------
module mm_checker
  import mm_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [CMD_W-1:0]     s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output changed");

  // a compute transfer makes the input busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_COMPUTE) |=> !s_axis_tready)
    else $error("input ready right after compute");

  // more entries pending keeps the input closed
  a_mid_frame: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input ready in the middle of a product");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind matrix_multiply_core mm_checker u_mm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
